// File: src/tmsc_pkg.sv
package tmsc_pkg;

    localparam int SIZE_W = 7;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [31:0] FP_ABS_MASK = 32'h7FFF_FFFF;
    localparam logic [31:0] FP_INF_ABS  = 32'h7F80_0000;

    typedef struct packed {
        logic        op;
        logic [31:0] element_in;
    } in_item_t;

    typedef struct packed {
        logic [31:0] element_out;
        logic        last_of_matrix;
        logic        is_symmetric;
        logic        matrix_loaded;
        logic        read_too_early;
    } out_item_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

// File: src/tmsc_store.sv
module tmsc_store #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_data
);

    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: src/tmsc_cmp.sv
module tmsc_cmp (
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic        equal
);

    logic [31:0] mag_a;
    logic [31:0] mag_b;

    assign mag_a = a & tmsc_pkg::FP_ABS_MASK;
    assign mag_b = b & tmsc_pkg::FP_ABS_MASK;

    always_comb
    begin
        if (mag_a > tmsc_pkg::FP_INF_ABS || mag_b > tmsc_pkg::FP_INF_ABS)
        begin
            equal = 1'b0;
        end
        else if (mag_a == 32'd0 && mag_b == 32'd0)
        begin
            equal = 1'b1;
        end
        else
        begin
            equal = (a == b);
        end
    end

endmodule

// File: src/matrix_transpose_symmetry_check.sv
// matrix transpose buffer with symmetry check
//
// input channel: in_item is taken at a rising edge with start high and busy low.
// op load writes the next element in row-major order and compares it with its
// stored mirror; op read gives the next transposed element of a loaded matrix.
// result channel: out_item is shown for exactly one cycle with done high; the
// receiver cannot stall, so every result must be taken when it appears.
// config: cfg_we with cfg_wdata writes the matrix size n (0 acts as 1, values
// above MAX_DIM act as MAX_DIM) and restarts the load and read pointers and
// the flags; write it only while the block is idle.
// handshake: busy rises for one cycle after each accepted item and done follows
// in the next cycle, so a new item can be started the cycle done is high. The
// element memory is read when an item is accepted, before the write-back of
// each item.
// reset: pointers go to 0, the symmetric flag to 1, the loaded flag to 0 and
// n to 64; the element memory is not cleared and needs no clearing pass.
module matrix_transpose_symmetry_check #(
    parameter int MAX_DIM = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  tmsc_pkg::in_item_t            in_item,
    output logic                          done,
    output tmsc_pkg::out_item_t           out_item,
    input  logic                          cfg_we,
    input  logic [tmsc_pkg::SIZE_W-1:0]   cfg_wdata
);

    localparam int PW    = $clog2(MAX_DIM);
    localparam int DW    = PW + 1;
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);

    tmsc_pkg::state_t state_reg;
    tmsc_pkg::state_t state_next;

    logic [tmsc_pkg::SIZE_W-1:0] size_reg;
    logic [PW-1:0]               load_row_reg;
    logic [PW-1:0]               load_col_reg;
    logic [PW-1:0]               read_row_reg;
    logic [PW-1:0]               read_col_reg;
    logic                        sym_reg;
    logic                        full_reg;
    tmsc_pkg::in_item_t          item_reg;
    logic                        cmp_en_reg;
    logic                        done_reg;
    tmsc_pkg::out_item_t         out_reg;

    logic [DW-1:0]  dim;
    logic           accept;
    logic           exec;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  wr_addr;
    logic           wr_en;
    logic [31:0]    rd_data;
    logic           mirror_eq;
    logic           load_col_end;
    logic           load_row_end;
    logic           read_col_end;
    logic           read_row_end;

    always_comb
    begin
        if (size_reg == '0)
        begin
            dim = DW'(1);
        end
        else if (int'(size_reg) > MAX_DIM)
        begin
            dim = DW'(MAX_DIM);
        end
        else
        begin
            dim = DW'(size_reg);
        end
    end

    assign load_col_end = !((DW'(load_col_reg) + DW'(1)) < dim);
    assign load_row_end = !((DW'(load_row_reg) + DW'(1)) < dim);
    assign read_col_end = !((DW'(read_col_reg) + DW'(1)) < dim);
    assign read_row_end = !((DW'(read_row_reg) + DW'(1)) < dim);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tmsc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = tmsc_pkg::ST_EXEC;
                end
            end
            tmsc_pkg::ST_EXEC:
            begin
                state_next = tmsc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tmsc_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the fsm
    always_comb
    begin
        busy = 1'b0;
        exec = 1'b0;
        case (state_reg)
            tmsc_pkg::ST_IDLE:
            begin
                busy = 1'b0;
            end
            tmsc_pkg::ST_EXEC:
            begin
                busy = 1'b1;
                exec = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    assign accept = start && !busy;

    // mirror element on load, transposed element on read
    always_comb
    begin
        if (in_item.op == tmsc_pkg::OP_LOAD)
        begin
            rd_addr = AW'(load_col_reg) * AW'(MAX_DIM) + AW'(load_row_reg);
        end
        else
        begin
            rd_addr = AW'(read_col_reg) * AW'(MAX_DIM) + AW'(read_row_reg);
        end
    end

    assign wr_addr = AW'(load_row_reg) * AW'(MAX_DIM) + AW'(load_col_reg);
    assign wr_en   = exec && (item_reg.op == tmsc_pkg::OP_LOAD);

    tmsc_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (item_reg.element_in),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tmsc_cmp u_cmp (
        .a     (item_reg.element_in),
        .b     (rd_data),
        .equal (mirror_eq)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tmsc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg   <= in_item;
            cmp_en_reg <= (load_col_reg < load_row_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg     <= tmsc_pkg::SIZE_RESET;
            load_row_reg <= '0;
            load_col_reg <= '0;
            read_row_reg <= '0;
            read_col_reg <= '0;
            sym_reg      <= 1'b1;
            full_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            size_reg     <= cfg_wdata;
            load_row_reg <= '0;
            load_col_reg <= '0;
            read_row_reg <= '0;
            read_col_reg <= '0;
            sym_reg      <= 1'b1;
            full_reg     <= 1'b0;
        end
        else if (exec)
        begin
            if (item_reg.op == tmsc_pkg::OP_LOAD)
            begin
                // a load after a full matrix starts a new one
                if (full_reg)
                begin
                    read_row_reg <= '0;
                    read_col_reg <= '0;
                end
                sym_reg <= (sym_reg || full_reg) && !(cmp_en_reg && !mirror_eq);
                if (!load_col_end)
                begin
                    load_col_reg <= load_col_reg + PW'(1);
                    full_reg     <= 1'b0;
                end
                else
                begin
                    load_col_reg <= '0;
                    if (!load_row_end)
                    begin
                        load_row_reg <= load_row_reg + PW'(1);
                        full_reg     <= 1'b0;
                    end
                    else
                    begin
                        load_row_reg <= '0;
                        full_reg     <= 1'b1;
                    end
                end
            end
            else if (full_reg)
            begin
                if (!read_col_end)
                begin
                    read_col_reg <= read_col_reg + PW'(1);
                end
                else
                begin
                    read_col_reg <= '0;
                    if (!read_row_end)
                    begin
                        read_row_reg <= read_row_reg + PW'(1);
                    end
                    else
                    begin
                        read_row_reg <= '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= exec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            if (item_reg.op == tmsc_pkg::OP_LOAD)
            begin
                out_reg.element_out    <= '0;
                out_reg.last_of_matrix <= load_col_end && load_row_end;
                out_reg.is_symmetric   <= (sym_reg || full_reg)
                                          && !(cmp_en_reg && !mirror_eq);
                out_reg.matrix_loaded  <= load_col_end && load_row_end;
                out_reg.read_too_early <= 1'b0;
            end
            else if (!full_reg)
            begin
                out_reg.element_out    <= '0;
                out_reg.last_of_matrix <= 1'b0;
                out_reg.is_symmetric   <= sym_reg;
                out_reg.matrix_loaded  <= 1'b0;
                out_reg.read_too_early <= 1'b1;
            end
            else
            begin
                out_reg.element_out    <= rd_data;
                out_reg.last_of_matrix <= read_col_end && read_row_end;
                out_reg.is_symmetric   <= sym_reg;
                out_reg.matrix_loaded  <= 1'b1;
                out_reg.read_too_early <= 1'b0;
            end
        end
    end

    assign done     = done_reg;
    assign out_item = out_reg;

endmodule

// File: src/tmsc_check.sv
module tmsc_check (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input tmsc_pkg::out_item_t out_item
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done && !busy)
        else $error("result did not follow the busy cycle");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_early_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && out_item.read_too_early |->
            out_item.element_out == 32'd0 && !out_item.last_of_matrix
            && !out_item.matrix_loaded)
        else $error("early read returned data");

    a_last_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        done && out_item.last_of_matrix |-> out_item.matrix_loaded)
        else $error("last element without a loaded matrix");

endmodule

bind matrix_transpose_symmetry_check tmsc_check u_tmsc_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .out_item (out_item)
);
